// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TPO_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tpo assertion failed");

// expression must never be true outside reset
`define TPO_NEVER(label, clk, rst_n, expr) \
	`TPO_ASSERT(label, clk, rst_n, !(expr))

`endif

// ===== rtl/tpo_pkg.sv =====
// package: types, codes and constants of the tick prescaler with timers
`default_nettype none
package tpo_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int TIMER_COUNT = 2;

	localparam int MODE_W  = 2;
	localparam int SEL_W   = 2;
	localparam int LOAD_W  = 16;
	localparam int DIV_W   = 8;
	localparam int CFG_IDX_W = 2;
	localparam int EV_W    = 5;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SET  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_POLL = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ACK  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIV_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIV_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIV_THIRD  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DIV_FOURTH = 2'd3;

	// reset values
	localparam logic [DIV_W-1:0] DIV_FIRST_RST  = 8'h0A;
	localparam logic [DIV_W-1:0] DIV_SECOND_RST = 8'h0A;
	localparam logic [DIV_W-1:0] DIV_THIRD_RST  = 8'h05;
	localparam logic [DIV_W-1:0] DIV_FOURTH_RST = 8'h02;
	localparam logic [DIV_W-1:0] CNT_FOURTH_RST = 8'h01;

	// event flag bit positions
	localparam int EV_1MS   = 0;
	localparam int EV_10MS  = 1;
	localparam int EV_100MS = 2;
	localparam int EV_500MS = 3;
	localparam int EV_1S    = 4;

	typedef logic [EV_W-1:0] ev_flags_t;
	typedef logic [TIMER_WIDTH-1:0] tmr_val_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SEL_W-1:0]  timer_select;
		logic [LOAD_W-1:0] load_value;
	} req_t;

	typedef struct packed {
		logic      accepted;
		logic      expired;
		ev_flags_t events;
	} rsp_t;

	typedef struct packed {
		logic                 wr;
		logic [CFG_IDX_W-1:0] idx;
		logic [DIV_W-1:0]     data;
	} cfg_wr_t;

	typedef struct packed {
		logic tick;
		logic ack;
	} psc_ctl_t;

	typedef struct packed {
		logic             step;
		logic             set;
		logic             poll;
		logic [SEL_W-1:0] sel;
		tmr_val_t         load;
	} tmr_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/tpo_if.sv =====
// channel interfaces: request, response and configuration write
`default_nettype none
interface tpo_req_if;
	logic                         valid;
	logic                         ready;
	logic [tpo_pkg::MODE_W-1:0]   mode;
	logic [tpo_pkg::SEL_W-1:0]    timer_select;
	logic [tpo_pkg::LOAD_W-1:0]   load_value;
	modport source (output valid, mode, timer_select, load_value, input ready);
	modport sink (input valid, mode, timer_select, load_value, output ready);
endinterface

interface tpo_rsp_if;
	logic valid;
	logic ready;
	logic accepted;
	logic expired;
	logic event_1ms;
	logic event_10ms;
	logic event_100ms;
	logic event_500ms;
	logic event_1s;
	modport source (output valid, accepted, expired, event_1ms, event_10ms,
		event_100ms, event_500ms, event_1s, input ready);
	modport sink (input valid, accepted, expired, event_1ms, event_10ms,
		event_100ms, event_500ms, event_1s, output ready);
endinterface

interface tpo_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [tpo_pkg::CFG_IDX_W-1:0]   index;
	logic [tpo_pkg::DIV_W-1:0]       data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tpo_prescaler.sv =====
// divider registers, prescaler cascade and event flags
`default_nettype none
`include "assert_macros.svh"
module tpo_prescaler (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tpo_pkg::cfg_wr_t  cfg_wr,
	input  wire tpo_pkg::psc_ctl_t ctl,
	output tpo_pkg::ev_flags_t     shown,
	output logic                   step_10ms
);
	logic [tpo_pkg::DIV_W-1:0] div1_q, div2_q, div3_q, div4_q;
	logic [tpo_pkg::DIV_W-1:0] cnt1_q, cnt2_q, cnt3_q, cnt4_q;
	logic [tpo_pkg::DIV_W-1:0] dec1, dec2, dec3, dec4;
	logic                      hit1, hit2, hit3, hit4;
	tpo_pkg::ev_flags_t        flags_q, flags_tick, ack_mask;

	assign dec1 = cnt1_q - 8'd1;
	assign dec2 = cnt2_q - 8'd1;
	assign dec3 = cnt3_q - 8'd1;
	assign dec4 = cnt4_q - 8'd1;
	assign hit1 = (dec1 == '0);
	assign hit2 = hit1 && (dec2 == '0);
	assign hit3 = hit2 && (dec3 == '0);
	assign hit4 = hit3 && (dec4 == '0);

	always_comb begin
		flags_tick = flags_q;
		flags_tick[tpo_pkg::EV_1MS]   = 1'b1;
		flags_tick[tpo_pkg::EV_10MS]  = flags_q[tpo_pkg::EV_10MS] | hit1;
		flags_tick[tpo_pkg::EV_100MS] = flags_q[tpo_pkg::EV_100MS] | hit2;
		flags_tick[tpo_pkg::EV_500MS] = flags_q[tpo_pkg::EV_500MS] | hit3;
		flags_tick[tpo_pkg::EV_1S]    = flags_q[tpo_pkg::EV_1S] | hit4;
		ack_mask = '1;
		ack_mask[tpo_pkg::EV_10MS]  = 1'b0;
		ack_mask[tpo_pkg::EV_100MS] = 1'b0;
		ack_mask[tpo_pkg::EV_500MS] = 1'b0;
	end

	assign shown     = ctl.tick ? flags_tick : flags_q;
	assign step_10ms = ctl.tick && hit1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div1_q <= tpo_pkg::DIV_FIRST_RST;
			div2_q <= tpo_pkg::DIV_SECOND_RST;
			div3_q <= tpo_pkg::DIV_THIRD_RST;
			div4_q <= tpo_pkg::DIV_FOURTH_RST;
		end else if (cfg_wr.wr) begin
			unique case (cfg_wr.idx)
				tpo_pkg::CFG_DIV_FIRST:  div1_q <= cfg_wr.data;
				tpo_pkg::CFG_DIV_SECOND: div2_q <= cfg_wr.data;
				tpo_pkg::CFG_DIV_THIRD:  div3_q <= cfg_wr.data;
				tpo_pkg::CFG_DIV_FOURTH: div4_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q  <= tpo_pkg::DIV_FIRST_RST;
			cnt2_q  <= tpo_pkg::DIV_SECOND_RST;
			cnt3_q  <= tpo_pkg::DIV_THIRD_RST;
			cnt4_q  <= tpo_pkg::CNT_FOURTH_RST;
			flags_q <= '0;
		end else if (ctl.tick) begin
			cnt1_q  <= hit1 ? div1_q : dec1;
			if (hit1) cnt2_q <= hit2 ? div2_q : dec2;
			if (hit2) cnt3_q <= hit3 ? div3_q : dec3;
			if (hit3) cnt4_q <= hit4 ? div4_q : dec4;
			flags_q <= flags_tick;
		end else if (ctl.ack) begin
			flags_q <= flags_q & ack_mask;
		end
	end

	// a tick always leaves the 1 ms flag set
	`TPO_ASSERT(a_tick_sets_1ms, clk, arst_n, ctl.tick |=> flags_q[tpo_pkg::EV_1MS])
	// the 1 s flag is never cleared once raised
	`TPO_ASSERT(a_1s_sticky, clk, arst_n, flags_q[tpo_pkg::EV_1S] |=> flags_q[tpo_pkg::EV_1S])
	// a 10 ms step only comes from a tick
	`TPO_NEVER(a_step_needs_tick, clk, arst_n, step_10ms && !ctl.tick)

endmodule
`default_nettype wire

// ===== rtl/tpo_timers.sv =====
// one-shot timer bank: set, poll and 10 ms countdown
`default_nettype none
`include "assert_macros.svh"
module tpo_timers (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tpo_pkg::tmr_ctl_t ctl,
	output logic                   accepted,
	output logic                   expired
);
	logic                                running_q [tpo_pkg::TIMER_COUNT];
	tpo_pkg::tmr_val_t                   value_q   [tpo_pkg::TIMER_COUNT];
	logic [tpo_pkg::TIMER_COUNT-1:0]     hit, fire, run_vec;

	always_comb begin
		for (int i = 0; i < tpo_pkg::TIMER_COUNT; i++) begin
			hit[i]     = (int'(ctl.sel) == i);
			fire[i]    = ctl.poll && hit[i] && running_q[i] && (value_q[i] == '0);
			run_vec[i] = running_q[i];
		end
	end

	assign accepted = ctl.set && (int'(ctl.sel) < tpo_pkg::TIMER_COUNT);
	assign expired  = |fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tpo_pkg::TIMER_COUNT; i++) begin
				running_q[i] <= 1'b0;
				value_q[i]   <= '0;
			end
		end else begin
			for (int i = 0; i < tpo_pkg::TIMER_COUNT; i++) begin
				if (ctl.set && hit[i]) begin
					running_q[i] <= (ctl.load != '0);
					value_q[i]   <= ctl.load;
				end else begin
					if (fire[i]) running_q[i] <= 1'b0;
					if (ctl.step && value_q[i] != '0)
						value_q[i] <= value_q[i] - tpo_pkg::tmr_val_t'(1);
				end
			end
		end
	end

	// an expiry report always retires one running timer
	`TPO_ASSERT(a_expiry_retires, clk, arst_n, expired |=> $countones(run_vec) < $past($countones(run_vec)))
	// only one operation reaches the bank at a time
	`TPO_NEVER(a_one_op, clk, arst_n, (ctl.set && ctl.poll) || (ctl.step && (ctl.set || ctl.poll)))

endmodule
`default_nettype wire

// ===== rtl/tick_prescaler_with_oneshot_timers_core.sv =====
// top level: request register, prescaler, timer bank and response register
// an accepted item waits in the request register; its response is held in the response register
// throughput: one item per cycle while the response side does not stall; the two registers overlap work
// a stalled response holds only the request register, which fills and then stalls the input
// config writes take effect at once and are always ready
// reset: asynchronous active-low arst_n presets dividers and counters and clears flags, timers and valids
`default_nettype none
`include "assert_macros.svh"
module tick_prescaler_with_oneshot_timers_core (
	input  wire logic clk,
	input  wire logic arst_n,
	tpo_req_if.sink   req,
	tpo_rsp_if.source rsp,
	tpo_cfg_if.sink   cfg
);
	// request register (stage 1)
	logic            req_v_s1;
	tpo_pkg::req_t   req_s1;
	// response register (stage 2)
	logic            rsp_v_s2;
	tpo_pkg::rsp_t   rsp_s2;

	logic               adv;
	tpo_pkg::cfg_wr_t   cfg_wr;
	tpo_pkg::psc_ctl_t  psc_ctl;
	tpo_pkg::tmr_ctl_t  tmr_ctl;
	tpo_pkg::ev_flags_t shown;
	logic               step_10ms;
	logic               accepted;
	logic               expired;

	// stage 1 item moves into the response register when that register is free or draining
	assign adv       = req_v_s1 && (!rsp_v_s2 || rsp.ready);
	assign req.ready = !req_v_s1 || adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_s1 <= 1'b0;
		end else if (req.ready) begin
			req_v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.mode         <= req.mode;
			req_s1.timer_select <= req.timer_select;
			req_s1.load_value   <= req.load_value;
		end
	end

	// counter, flag and timer state only changes when the item leaves stage 1; divider writes do not wait
	always_comb begin
		cfg_wr.wr     = cfg.valid;
		cfg_wr.idx    = cfg.index;
		cfg_wr.data   = cfg.data;
		psc_ctl.tick  = adv && (req_s1.mode == tpo_pkg::MODE_TICK);
		psc_ctl.ack   = adv && (req_s1.mode == tpo_pkg::MODE_ACK);
		tmr_ctl.step  = step_10ms;
		tmr_ctl.set   = adv && (req_s1.mode == tpo_pkg::MODE_SET);
		tmr_ctl.poll  = adv && (req_s1.mode == tpo_pkg::MODE_POLL);
		tmr_ctl.sel   = req_s1.timer_select;
		tmr_ctl.load  = tpo_pkg::tmr_val_t'(req_s1.load_value);
	end

	tpo_prescaler u_prescaler (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.ctl       (psc_ctl),
		.shown     (shown),
		.step_10ms (step_10ms)
	);

	tpo_timers u_timers (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tmr_ctl),
		.accepted (accepted),
		.expired  (expired)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_s2 <= 1'b0;
		end else if (adv) begin
			rsp_v_s2 <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_s2 <= 1'b0;
		end
	end

	// flags shown are post-tick for a tick and pre-clear for an acknowledge
	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2.accepted <= accepted;
			rsp_s2.expired  <= expired;
			rsp_s2.events   <= shown;
		end
	end

	assign rsp.valid       = rsp_v_s2;
	assign rsp.accepted    = rsp_s2.accepted;
	assign rsp.expired     = rsp_s2.expired;
	assign rsp.event_1ms   = rsp_s2.events[tpo_pkg::EV_1MS];
	assign rsp.event_10ms  = rsp_s2.events[tpo_pkg::EV_10MS];
	assign rsp.event_100ms = rsp_s2.events[tpo_pkg::EV_100MS];
	assign rsp.event_500ms = rsp_s2.events[tpo_pkg::EV_500MS];
	assign rsp.event_1s    = rsp_s2.events[tpo_pkg::EV_1S];

	// a blocked stage 1 item keeps its slot
	`TPO_ASSERT(a_s1_hold, clk, arst_n, (req_v_s1 && !adv) |=> req_v_s1)
	// a result register holding an unaccepted item is never overwritten
	`TPO_NEVER(a_no_overwrite, clk, arst_n, adv && rsp_v_s2 && !rsp.ready)

endmodule
`default_nettype wire

// ===== tb/tb_tick_prescaler_with_oneshot_timers_core.sv =====
// testbench: tick prescaler with one-shot timers, self-checking against a behavioral predictor
`default_nettype none
module tb_tick_prescaler_with_oneshot_timers_core;
	timeunit 1ns;
	timeprecision 1ps;
	import tpo_pkg::*;

	// run length guard, far above the slowest legal run
	localparam int CYCLE_LIMIT  = 400000;
	// length of the forced response back-pressure window
	localparam int STALL_CYCLES = 80;

	// behavioral copy of the prescaler cascade and timer bank, plus the
	// queue of responses that the block still owes
	class tpo_scoreboard;
		logic [DIV_W-1:0] divider [4];
		logic [DIV_W-1:0] stage_count [4];
		ev_flags_t        flags;
		logic             running [TIMER_COUNT];
		tmr_val_t         timer_val [TIMER_COUNT];
		rsp_t             owed_rsp [$];
		int               failures;

		function new();
			divider     = '{DIV_FIRST_RST, DIV_SECOND_RST, DIV_THIRD_RST, DIV_FOURTH_RST};
			stage_count = '{DIV_FIRST_RST, DIV_SECOND_RST, DIV_THIRD_RST, CNT_FOURTH_RST};
			flags       = '0;
			foreach (running[i]) begin
				running[i]   = 1'b0;
				timer_val[i] = '0;
			end
			failures = 0;
		endfunction

		function void write_divider(logic [CFG_IDX_W-1:0] index, logic [DIV_W-1:0] data);
			divider[index] = data;
		endfunction

		// one 1 ms tick: sets the 1 ms flag; each stage that reaches zero flags its event,
		// reloads from its divider and steps the next stage; the first stage also steps the timers
		function void advance_tick();
			flags[EV_1MS] = 1'b1;
			for (int s = 0; s < 4; s++) begin
				stage_count[s] = stage_count[s] - 1'b1;
				if (stage_count[s] != '0)
					return;
				if (s == 0) begin
					foreach (timer_val[i])
						if (timer_val[i] != '0)
							timer_val[i] = timer_val[i] - 1'b1;
				end
				flags[EV_10MS + s] = 1'b1;
				stage_count[s] = divider[s];
			end
		endfunction

		function void note_request(req_t r);
			rsp_t want;
			want = '0;
			case (r.mode)
			MODE_TICK: advance_tick();
			MODE_SET: begin
				if (r.timer_select < TIMER_COUNT) begin
					running[r.timer_select]   = (r.load_value != '0);
					timer_val[r.timer_select] = r.load_value;
					want.accepted = 1'b1;
				end
			end
			MODE_POLL: begin
				if (r.timer_select < TIMER_COUNT && running[r.timer_select] &&
						timer_val[r.timer_select] == '0) begin
					want.expired = 1'b1;
					running[r.timer_select] = 1'b0;
				end
			end
			default: ;
			endcase
			want.events = flags;
			if (r.mode == MODE_ACK) begin
				flags[EV_10MS]  = 1'b0;
				flags[EV_100MS] = 1'b0;
				flags[EV_500MS] = 1'b0;
			end
			owed_rsp.push_back(want);
		endfunction

		function void check_response(rsp_t got);
			rsp_t  want;
			string ev_name [EV_W] = '{"event_1ms", "event_10ms", "event_100ms",
				"event_500ms", "event_1s"};
			if (owed_rsp.size() == 0) begin
				$error("response item with no request outstanding");
				failures++;
				return;
			end
			want = owed_rsp.pop_front();
			if (got.accepted !== want.accepted) begin
				$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
				failures++;
			end
			if (got.expired !== want.expired) begin
				$error("expired: expected %0d, got %0d", want.expired, got.expired);
				failures++;
			end
			for (int b = 0; b < EV_W; b++) begin
				if (got.events[b] !== want.events[b]) begin
					$error("%s: expected %0d, got %0d", ev_name[b], want.events[b],
						got.events[b]);
					failures++;
				end
			end
		endfunction

		function int owed();
			return owed_rsp.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tpo_req_if req_if ();
	tpo_rsp_if rsp_if ();
	tpo_cfg_if cfg_if ();

	tick_prescaler_with_oneshot_timers_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	tpo_scoreboard sb = new();

	// idle percentages for the request sender and the response receiver
	int send_idle = 34;
	int recv_idle = 75;
	// raised by the stimulus to ask the receiver for a long hold-off
	bit stall_request = 1'b0;
	int stall_left = 0;
	int cycle_count = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// every input known from time zero
	initial begin
		arst_n               = 1'b0;
		req_if.valid         = 1'b0;
		req_if.mode          = MODE_TICK;
		req_if.timer_select  = '0;
		req_if.load_value    = '0;
		cfg_if.valid         = 1'b0;
		cfg_if.index         = CFG_DIV_FIRST;
		cfg_if.data          = '0;
		rsp_if.ready         = 1'b0;
	end

	// receiver: random back-pressure, or a counted hold-off when asked for one
	always @(negedge clk) begin
		if (stall_request) begin
			stall_left = STALL_CYCLES;
			stall_request = 1'b0;
		end
		if (stall_left > 0) begin
			rsp_if.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor: all handshakes are seen at the rising edge, before the block updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready)
				sb.check_response('{accepted: rsp_if.accepted, expired: rsp_if.expired,
					events: {rsp_if.event_1s, rsp_if.event_500ms, rsp_if.event_100ms,
					rsp_if.event_10ms, rsp_if.event_1ms}});
			if (req_if.valid && req_if.ready)
				sb.note_request('{mode: req_if.mode, timer_select: req_if.timer_select,
					load_value: req_if.load_value});
			if (cfg_if.valid && cfg_if.ready)
				sb.write_divider(cfg_if.index, cfg_if.data);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// offer one request item, with random idle cycles ahead of it; returns at
	// the rising edge where it is taken
	task automatic send_item(logic [MODE_W-1:0] mode, logic [SEL_W-1:0] sel,
			logic [LOAD_W-1:0] load);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.mode         <= mode;
		req_if.timer_select <= sel;
		req_if.load_value   <= load;
		do @(posedge clk); while (!req_if.ready);
	endtask

	// stop offering and wait until every owed response has come back
	task automatic drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (sb.owed() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// write all four dividers back to back; only called with the block drained
	task automatic set_dividers(logic [DIV_W-1:0] d0, logic [DIV_W-1:0] d1,
			logic [DIV_W-1:0] d2, logic [DIV_W-1:0] d3);
		logic [DIV_W-1:0] vals [4];
		logic [CFG_IDX_W-1:0] idx [4];
		vals = '{d0, d1, d2, d3};
		idx  = '{CFG_DIV_FIRST, CFG_DIV_SECOND, CFG_DIV_THIRD, CFG_DIV_FOURTH};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_if.valid <= 1'b1;
			cfg_if.index <= idx[i];
			cfg_if.data  <= vals[i];
			do @(posedge clk); while (!cfg_if.ready);
		end
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// mostly ticks, sets and polls on real timers with short lengths so that
	// timers actually expire; some invalid ids and wide or extreme lengths
	function automatic req_t random_request();
		req_t r;
		int   pick;
		pick = $urandom_range(99);
		if (pick < 45)
			r.mode = MODE_TICK;
		else if (pick < 65)
			r.mode = MODE_SET;
		else if (pick < 87)
			r.mode = MODE_POLL;
		else
			r.mode = MODE_ACK;
		if ($urandom_range(9) == 0)
			r.timer_select = $urandom_range(3);
		else
			r.timer_select = $urandom_range(TIMER_COUNT - 1);
		pick = $urandom_range(99);
		if (pick < 70)
			r.load_value = $urandom_range(6);
		else if (pick < 92)
			r.load_value = $urandom;
		else
			r.load_value = '1;
		return r;
	endfunction

	// one configuration phase: drain, reprogram, then random items;
	// optionally asks for the long receiver hold-off part way through
	task automatic run_phase(logic [DIV_W-1:0] d0, logic [DIV_W-1:0] d1,
			logic [DIV_W-1:0] d2, logic [DIV_W-1:0] d3, int n_items, bit with_stall);
		req_t r;
		drain();
		set_dividers(d0, d1, d2, d3);
		for (int i = 0; i < n_items; i++) begin
			if (with_stall && i == 40)
				stall_request = 1'b1;
			r = random_request();
			send_item(r.mode, r.timer_select, r.load_value);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at the reset dividers (10, 10, 5, 2)
		send_item(MODE_POLL, 2'd0, 16'd0);       // idle timer, nothing to report
		send_item(MODE_ACK,  2'd0, 16'd0);       // all flags still clear
		send_item(MODE_SET,  2'd0, 16'd1);       // shortest running timer
		send_item(MODE_SET,  2'd1, 16'hFFFF);    // longest timer
		send_item(MODE_SET,  2'd2, 16'd5);       // id out of range is refused
		send_item(MODE_SET,  2'd3, 16'hFFFF);
		send_item(MODE_POLL, 2'd3, 16'hFFFF);    // poll of a missing timer
		send_item(MODE_POLL, 2'd0, 16'd0);       // running but not yet at zero
		for (int i = 0; i < 10; i++)             // first 10 ms event steps both timers
			send_item(MODE_TICK, 2'(i), 16'(i * 16'h1111));
		send_item(MODE_POLL, 2'd0, 16'd0);       // expiry reported once
		send_item(MODE_POLL, 2'd0, 16'd0);       // and then the timer is idle
		send_item(MODE_ACK,  2'd3, 16'hFFFF);    // shows 10 ms, then clears it
		send_item(MODE_ACK,  2'd0, 16'd0);       // 1 ms stays sticky
		send_item(MODE_SET,  2'd1, 16'd0);       // length zero leaves the timer idle
		send_item(MODE_POLL, 2'd1, 16'd0);
		send_item(MODE_TICK, 2'd0, 16'd0);

		// once the counters reload, every tick is an event on every stage, sticky 1 s shows at once;
		// long receiver hold-off fills the block while requests keep coming
		run_phase(8'd1, 8'd1, 8'd1, 8'd1, 180, 1'b1);
		// largest nonzero dividers
		run_phase(8'd255, 8'd255, 8'd255, 8'd255, 120, 1'b0);

		send_idle = 75;
		recv_idle = 34;
		run_phase(8'd3, 8'd2, 8'd2, 8'd3, 200, 1'b0);
		// zero dividers reload to zero and divide by 256
		run_phase(8'd0, 8'd1, 8'd0, 8'd1, 100, 1'b0);

		send_idle = 0;
		recv_idle = 0;
		run_phase(8'd2, 8'd1, 8'd1, 8'd2, 180, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (sb.failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
